[rtl/glob_wildcard_matcher_core_assert.svh]
// Assertion macros for the glob wildcard matcher.
// Included by rtl modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef GLOB_WILDCARD_MATCHER_CORE_ASSERT_SVH
`define GLOB_WILDCARD_MATCHER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define GWM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define GWM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gwm_pkg.sv]
// Shared types and constants for the glob wildcard matcher.
// No dependencies; imported by gwm_cell, gwm_skid and glob_wildcard_matcher_core.
`timescale 1ns / 1ps

package gwm_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int POS_COUNT   = PATTERN_MAX + 1;
    localparam int LEN_W       = $clog2(POS_COUNT);
    localparam int LEN_REG_W   = 6;
    localparam int CHAR_W      = 8;
    localparam int DATA_W      = 64;
    localparam int WORD_CHARS  = DATA_W / CHAR_W;
    localparam int PAT_WORDS   = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int OUT_DATA_W  = 8;

    localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
    localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_PAT_LOW    = 3'd0;
    localparam cfg_idx_t REG_PAT_SECOND = 3'd1;
    localparam cfg_idx_t REG_PAT_THIRD  = 3'd2;
    localparam cfg_idx_t REG_PAT_HIGH   = 3'd3;
    localparam cfg_idx_t REG_PAT_LEN    = 3'd4;

    typedef struct packed {
        logic              accept;
        logic              present;
        logic              last;
        logic [CHAR_W-1:0] text_char;
    } cell_ctrl_t;

    typedef struct packed {
        logic cur_star;
        logic next_star;
        logic advance;
    } cell_link_t;

    typedef struct packed {
        logic match_bit;
        logic done;
    } result_t;

endpackage

[rtl/gwm_cell.sv]
// One pattern position of the matcher chain: holds its reached bit.
// Depends on gwm_pkg; chained by glob_wildcard_matcher_core.
`timescale 1ns / 1ps

module gwm_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  gwm_pkg::cell_ctrl_t      ctrl,
    input  logic [gwm_pkg::CHAR_W-1:0] pat_char,
    input  logic                     active,
    input  gwm_pkg::cell_link_t      link_in,
    output gwm_pkg::cell_link_t      link_out,
    output logic                     next_bit
);
    import gwm_pkg::*;

    logic reached_reg;
    logic reached_next;
    logic cur;
    logic is_star;
    logic hit;
    logic next_raw;
    logic nxt;

    always_comb
    begin
        cur      = reached_reg | link_in.cur_star;
        is_star  = active && (pat_char == STAR_CHAR);
        hit      = active && !is_star &&
                   ((pat_char == ANY_CHAR) || (pat_char == ctrl.text_char));
        next_raw = (cur & is_star) | link_in.advance;
        nxt      = ctrl.present ? (next_raw | link_in.next_star) : cur;

        link_out.cur_star  = cur & is_star;
        link_out.next_star = nxt & is_star;
        link_out.advance   = cur & hit;

        reached_next = ctrl.last ? 1'b0 : nxt;
    end

    assign next_bit = nxt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reached_reg <= 1'b0;
        end
        else if (ctrl.accept)
        begin
            reached_reg <= reached_next;
        end
    end

endmodule

[rtl/gwm_skid.sv]
// Output register plus skid word between the matcher and the result stream.
// Depends on gwm_pkg and glob_wildcard_matcher_core_assert.svh.
`timescale 1ns / 1ps

`include "glob_wildcard_matcher_core_assert.svh"

module gwm_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  gwm_pkg::result_t in_word,
    output logic             in_ready,
    output logic             out_valid,
    output gwm_pkg::result_t out_word,
    input  logic             out_ready
);
    import gwm_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_word_reg;
    result_t out_word_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_word_reg;
    result_t skid_word_next;
    logic    in_fire;
    logic    out_free;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
            else if (in_fire)
            begin
                out_valid_next = 1'b1;
                out_word_next  = in_word;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_word_next  = in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    `GWM_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid word without output word")
    `GWM_ASSERT_NXT(a_stall_to_skid, in_fire && out_valid_reg && !out_ready, skid_valid_reg, "stalled word not parked in skid")
    `GWM_ASSERT_NXT(a_skid_drain, skid_valid_reg && out_ready, out_valid_reg && !skid_valid_reg, "skid word not moved to output")

endmodule

[rtl/glob_wildcard_matcher_core.sv]
// Top level of the streamed glob matcher: config registers, cell chain, output skid.
// Depends on gwm_pkg, gwm_cell, gwm_skid and glob_wildcard_matcher_core_assert.svh.
//
//  channel | direction | ports                                   | word
//  s_      | in        | s_tvalid s_tready s_tdata s_tuser s_tlast | one text byte
//  m_      | out       | m_tvalid m_tready m_tdata m_tlast         | one match result
//  cfg_    | in        | cfg_valid cfg_ready cfg_index cfg_data  | one register write
//
// One text byte per cycle while s_tready is high; each result is registered.
// Per cycle the reached set runs through a chain of 33 cells twice (star closure
// before and after the byte), which sets the critical path.
// Reset clears the pattern, sets the start-of-string flag and empties the output.
// A stalled result parks in a skid word; s_tready drops only when that is full.
`timescale 1ns / 1ps

`include "glob_wildcard_matcher_core_assert.svh"

module glob_wildcard_matcher_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [gwm_pkg::CHAR_W-1:0] s_tdata,     // [7:0] text_char
    input  logic                      s_tuser,      // [0] char_present
    input  logic                      s_tlast,      // last_char
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [gwm_pkg::OUT_DATA_W-1:0] m_tdata, // [0] matches_so_far, [7:1] zero
    output logic                      m_tlast,      // string_done
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  gwm_pkg::cfg_idx_t         cfg_index,
    input  logic [gwm_pkg::DATA_W-1:0] cfg_data
);
    import gwm_pkg::*;

    logic [DATA_W-1:0]    pat_word_reg [PAT_WORDS];
    logic [LEN_REG_W-1:0] pat_len_reg;
    logic [LEN_W-1:0]     len_eff;
    logic                 fresh_reg;
    logic                 accept;
    cell_ctrl_t           ctrl;
    cell_link_t           links [POS_COUNT+1];
    logic [POS_COUNT-1:0] next_bits;
    result_t              res;
    result_t              out_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAT_WORDS; i++)
            begin
                pat_word_reg[i] <= '0;
            end
            pat_len_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PAT_LOW:    pat_word_reg[0] <= cfg_data;
                REG_PAT_SECOND: pat_word_reg[1] <= cfg_data;
                REG_PAT_THIRD:  pat_word_reg[2] <= cfg_data;
                REG_PAT_HIGH:   pat_word_reg[3] <= cfg_data;
                REG_PAT_LEN:    pat_len_reg     <= cfg_data[LEN_REG_W-1:0];
                default:        ;
            endcase
        end
    end

    assign len_eff = (pat_len_reg > LEN_REG_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                            : pat_len_reg[LEN_W-1:0];

    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        ctrl.accept    = accept;
        ctrl.present   = s_tuser;
        ctrl.last      = s_tlast;
        ctrl.text_char = s_tdata;
    end

    // start of string seeds position zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg <= 1'b1;
        end
        else if (accept)
        begin
            fresh_reg <= s_tlast;
        end
    end

    assign links[0] = '{cur_star: fresh_reg, next_star: 1'b0, advance: 1'b0};

    for (genvar p = 0; p < POS_COUNT; p++)
    begin : g_cell
        logic [CHAR_W-1:0] pat_char;
        logic              active;

        if (p < PATTERN_MAX)
        begin : g_char
            assign pat_char = pat_word_reg[p / WORD_CHARS][(p % WORD_CHARS) * CHAR_W +: CHAR_W];
        end
        else
        begin : g_end
            assign pat_char = '0;
        end

        assign active = LEN_W'(p) < len_eff;

        gwm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .pat_char (pat_char),
            .active   (active),
            .link_in  (links[p]),
            .link_out (links[p+1]),
            .next_bit (next_bits[p])
        );
    end

    always_comb
    begin
        res.match_bit = next_bits[len_eff];
        res.done      = s_tlast;
    end

    gwm_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_word   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_word  (out_word),
        .out_ready (m_tready)
    );

    assign m_tdata = {{(OUT_DATA_W-1){1'b0}}, out_word.match_bit};
    assign m_tlast = out_word.done;

    `GWM_ASSERT_NXT(a_last_restarts, accept && s_tlast, fresh_reg, "string end did not restart the set")
    `GWM_ASSERT_NXT(a_mid_not_fresh, accept && !s_tlast, !fresh_reg, "start flag kept inside a string")
    `GWM_ASSERT_NXT(a_result_shown, accept, m_tvalid, "accepted byte gave no result")
    `GWM_ASSERT_IMP(a_len_clamped, 1'b1, len_eff <= LEN_W'(PATTERN_MAX), "pattern length not clamped")

endmodule

[bench/tb.sv]
// Testbench for glob_wildcard_matcher_core: streams text words against configured glob patterns
// and checks every result word against a bit-vector predictor of the reached pattern positions.
// Depends on gwm_pkg and the RTL of glob_wildcard_matcher_core.
`timescale 1ns / 1ps

module tb;

    import gwm_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 1750;
    localparam int MAX_PRINTS   = 40;
    localparam int LEN_MAX      = (1 << LEN_REG_W) - 1;

    localparam cfg_idx_t REG_UNUSED_FIRST = REG_PAT_LEN + 1'b1;
    localparam cfg_idx_t REG_UNUSED_LAST  = '1;
    localparam logic [CHAR_W-1:0] FIRST_LETTER = "a";

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [CHAR_W-1:0]     s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = REG_PAT_LOW;
    logic [DATA_W-1:0]     cfg_data  = '0;

    // predictor copy of pattern registers and reached set
    logic [DATA_W-1:0]    pat_word [PAT_WORDS] = '{default: '0};
    logic [LEN_REG_W-1:0] pat_len = '0;
    logic [POS_COUNT-1:0] reached = POS_COUNT'(1);

    result_t match_expect [$];
    result_t oldest;

    int mismatch_count = 0;
    int sent_items     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int absent_pct     = 0;
    int quiet_cycles   = 0;

    always #1 clk = ~clk;

    glob_wildcard_matcher_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---------------- predictor ----------------

    function automatic logic [CHAR_W-1:0] glob_char_at(int p);
        return pat_word[p / WORD_CHARS][(p % WORD_CHARS) * CHAR_W +: CHAR_W];
    endfunction

    // carry reached positions across '*' characters
    function automatic logic [POS_COUNT-1:0] star_fill(logic [POS_COUNT-1:0] set, int len);
        for (int p = 0; p < len; p++)
            if (set[p] && glob_char_at(p) == STAR_CHAR)
                set[p + 1] = 1'b1;
        return set;
    endfunction

    function automatic result_t glob_advance(logic [CHAR_W-1:0] c, logic present, logic last);
        int                   len;
        logic [POS_COUNT-1:0] cur;
        logic [POS_COUNT-1:0] nxt;
        result_t              r;
        len = (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
        cur = star_fill(reached, len);
        if (present)
        begin
            nxt = '0;
            for (int p = 0; p < len; p++)
            begin
                if (cur[p])
                begin
                    if (glob_char_at(p) == STAR_CHAR)
                        nxt[p] = 1'b1;
                    else if (glob_char_at(p) == ANY_CHAR || glob_char_at(p) == c)
                        nxt[p + 1] = 1'b1;
                end
            end
            nxt = star_fill(nxt, len);
        end
        else
            nxt = cur;
        r.match_bit = nxt[len];
        r.done      = last;
        reached     = last ? POS_COUNT'(1) : nxt;
        return r;
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTS)
            $display("ERROR %0t: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (match_expect.size() == 0)
                report_mismatch("result word with nothing expected");
            else
            begin
                oldest = match_expect.pop_front();
                if (m_tdata !== OUT_DATA_W'(oldest.match_bit))
                    report_mismatch($sformatf("m_tdata %h, expected %h",
                                              m_tdata, OUT_DATA_W'(oldest.match_bit)));
                if (m_tlast !== oldest.done)
                    report_mismatch($sformatf("m_tlast %b, expected %b", m_tlast, oldest.done));
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("ERROR %0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // ---------------- drivers ----------------

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic present, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= present;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        match_expect.push_back(glob_advance(c, present, last));
        sent_items++;
    endtask

    task automatic send_string(input logic [CHAR_W-1:0] txt [$]);
        logic tail_absent;
        tail_absent = ($urandom_range(99) < absent_pct);
        for (int i = 0; i < txt.size(); i++)
        begin
            if ($urandom_range(99) < absent_pct)
                send_char(CHAR_W'($urandom), 1'b0, 1'b0);
            send_char(txt[i], 1'b1, (i == txt.size() - 1) && !tail_absent);
        end
        if (txt.size() == 0 || tail_absent)
            send_char(CHAR_W'($urandom), 1'b0, 1'b1);
    endtask

    task automatic send_text(input string s);
        logic [CHAR_W-1:0] txt [$];
        for (int i = 0; i < s.len(); i++)
            txt.push_back(s[i]);
        send_string(txt);
    endtask

    // sender pauses until every result word is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (match_expect.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic [DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_PAT_LOW, REG_PAT_SECOND, REG_PAT_THIRD, REG_PAT_HIGH:
                pat_word[2'(idx - REG_PAT_LOW)] = value;
            REG_PAT_LEN:
                pat_len = value[LEN_REG_W-1:0];
            default:
                ;
        endcase
    endtask

    task automatic load_pattern(input logic [CHAR_W-1:0] pc [PATTERN_MAX],
                                input logic [LEN_REG_W-1:0] len);
        logic [DATA_W-1:0] w;
        drain_results();
        for (int i = 0; i < PAT_WORDS; i++)
        begin
            for (int j = 0; j < WORD_CHARS; j++)
                w[j * CHAR_W +: CHAR_W] = pc[i * WORD_CHARS + j];
            cfg_write(REG_PAT_LOW + cfg_idx_t'(i), w);
        end
        // upper bits of the length word carry noise
        w = {$urandom, $urandom};
        w[LEN_REG_W-1:0] = len;
        cfg_write(REG_PAT_LEN, w);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_glob(input string glob, input logic [CHAR_W-1:0] fill,
                             input logic [LEN_REG_W-1:0] len);
        logic [CHAR_W-1:0] pc [PATTERN_MAX];
        for (int i = 0; i < PATTERN_MAX; i++)
            pc[i] = (i < glob.len()) ? glob[i] : fill;
        load_pattern(pc, len);
    endtask

    // ---------------- random generation ----------------

    function automatic logic [CHAR_W-1:0] random_letter();
        return FIRST_LETTER + CHAR_W'($urandom_range(2));
    endfunction

    function automatic logic [CHAR_W-1:0] random_glob_char();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20)
            return STAR_CHAR;
        else if (pick < 35)
            return ANY_CHAR;
        else if (pick < 95)
            return random_letter();
        return CHAR_W'($urandom);
    endfunction

    task automatic random_pattern(output logic [CHAR_W-1:0] pc [PATTERN_MAX],
                                  output logic [LEN_REG_W-1:0] len);
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            len = '0;
        else if (pick < 80)
            len = LEN_REG_W'($urandom_range(1, 8));
        else if (pick < 93)
            len = LEN_REG_W'($urandom_range(9, 20));
        else if (pick < 97)
            len = LEN_REG_W'($urandom_range(21, PATTERN_MAX));
        else
            len = LEN_REG_W'($urandom_range(PATTERN_MAX + 1, LEN_MAX));
        for (int i = 0; i < PATTERN_MAX; i++)
            pc[i] = (i < len) ? random_glob_char() : CHAR_W'($urandom);
    endtask

    // mostly texts that fit the glob, some mutated, some pure noise
    task automatic make_text(input logic [CHAR_W-1:0] pc [PATTERN_MAX],
                             input logic [LEN_REG_W-1:0] len,
                             output logic [CHAR_W-1:0] txt [$]);
        int used;
        int pick;
        int at;
        txt  = {};
        used = (len > PATTERN_MAX) ? PATTERN_MAX : int'(len);
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            repeat ($urandom_range(0, 12))
                txt.push_back(CHAR_W'($urandom));
        end
        else
        begin
            for (int i = 0; i < used; i++)
            begin
                if (pc[i] == STAR_CHAR)
                    repeat ($urandom_range(0, 3))
                        txt.push_back(random_letter());
                else if (pc[i] == ANY_CHAR)
                    txt.push_back(CHAR_W'($urandom));
                else
                    txt.push_back(pc[i]);
            end
            if (pick < 40)
            begin
                at = $urandom_range(0, txt.size());
                case ($urandom_range(3))
                    0:
                        if (txt.size() > 0)
                            txt.delete(at % txt.size());
                    1:
                        txt.insert(at, random_letter());
                    2:
                        if (txt.size() > 0)
                            txt[at % txt.size()] = random_letter();
                    default:
                        txt.push_back(random_letter());
                endcase
            end
        end
    endtask

    // ---------------- tests ----------------

    // reset state: empty pattern, only the empty text matches
    task automatic test_empty_pattern();
        send_char(8'h00, 1'b0, 1'b1);
        send_char(8'h00, 1'b1, 1'b1);
        send_char(8'hFF, 1'b1, 1'b1);
    endtask

    task automatic test_unknown_register();
        load_glob("ab", 8'h00, 2);
        drain_results();
        for (int k = REG_UNUSED_FIRST; k <= REG_UNUSED_LAST; k++)
            cfg_write(cfg_idx_t'(k), '1);
        cfg_valid <= 1'b0;
        send_text("ab");
    endtask

    task automatic test_byte_extremes();
        load_glob("", 8'hFF, 2);
        send_char(8'hFF, 1'b1, 1'b0);
        send_char(8'hFF, 1'b1, 1'b1);
        load_glob("", 8'h00, 1);
        send_char(8'h00, 1'b1, 1'b1);
    endtask

    // 31 stars then a literal; length above the maximum is clamped
    task automatic test_long_length();
        logic [CHAR_W-1:0] pc [PATTERN_MAX];
        for (int i = 0; i < PATTERN_MAX; i++)
            pc[i] = STAR_CHAR;
        pc[PATTERN_MAX - 1] = FIRST_LETTER;
        load_pattern(pc, LEN_MAX);
        send_text("a");
        send_text("ab");
        load_pattern(pc, PATTERN_MAX);
        send_text("za");
    endtask

    task automatic test_star_and_any();
        load_glob("a?*b", 8'h55, 4);
        send_char("a", 1'b1, 1'b0);
        send_char(8'hC3, 1'b0, 1'b0);
        send_char("x", 1'b1, 1'b0);
        send_char("b", 1'b1, 1'b1);
        send_text("ab");
    endtask

    // byte past the pattern end must fail even when the fill would match
    task automatic test_past_end();
        load_glob("ab", "c", 2);
        send_text("abc");
    endtask

    // pattern changed between two bytes of one string
    task automatic test_pattern_swap();
        load_glob("ab", 8'h00, 2);
        send_char("a", 1'b1, 1'b0);
        load_glob("a*", 8'h00, 2);
        send_char(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_items);
        logic [CHAR_W-1:0]    pc [PATTERN_MAX];
        logic [LEN_REG_W-1:0] len;
        logic [CHAR_W-1:0]    txt [$];
        int                   stop_at;
        stop_at        = sent_items + n_items;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        absent_pct     = 4;
        while (sent_items < stop_at)
        begin
            random_pattern(pc, len);
            load_pattern(pc, len);
            repeat ($urandom_range(3, 8))
            begin
                make_text(pc, len, txt);
                send_string(txt);
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_pattern();
        test_unknown_register();
        test_byte_extremes();
        test_long_length();
        test_star_and_any();
        test_past_end();
        test_pattern_swap();
        test_random_traffic(0, 0, RANDOM_ITEMS / 4);
        test_random_traffic(82, 0, RANDOM_ITEMS / 4);
        test_random_traffic(0, 82, RANDOM_ITEMS / 4);
        test_random_traffic(10, 10, RANDOM_ITEMS / 4);
        drain_results();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
